@@ hdl/dbb_pkg.sv @@
package dbb_pkg;

  // Near cut: 0.1 m in Q8.16
  localparam logic [31:0] MIN_Z = 32'd6553;

  typedef enum logic [2:0] {
    REG_BOX_START       = 3'd0,
    REG_BOX_END         = 3'd1,
    REG_CENTER_X        = 3'd2,
    REG_CENTER_Y        = 3'd3,
    REG_INV_FOCAL_X     = 3'd4,
    REG_INV_FOCAL_Y     = 3'd5,
    REG_INV_DEPTH_SCALE = 3'd6,
    REG_MAX_DEPTH       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] box_start;
    logic [23:0] box_end;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [23:0] inv_depth_scale;
    logic [23:0] max_depth;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [23:0] z;
    logic [15:0] mag_x;
    logic        neg_x;
    logic [15:0] mag_y;
    logic        neg_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } item_t;

endpackage

@@ hdl/depth_box_backprojection_unit.sv @@
// Depth box back-projection: turns depth pixels into 3D points (pinhole model,
// Q8.16 meters). Input stream s_*: one transaction per pixel. Output stream
// m_*: one transaction per kept point; pixels outside the box, off the sample
// lattice, nearer than 0.1 m or beyond max_depth produce no transaction.
// The APB port sets the box, principal point, reciprocal focal lengths, depth
// scale and far cut; write it only while the stream is idle.
//
// Throughput: one pixel per clock while s_tready is high. A pixel passes
// two front stages (box, lattice and depth checks), one queue slot, two back
// multiply stages and the output register on its way to m_tvalid.
// s_tready is set by the point queue: it drops only when the queued points
// plus the pixels still in the front could fill the QUEUE_DEPTH entries.
// When the receiver stalls, the output register holds its point, the back
// pipe freezes, and the front keeps accepting until the queue is spoken for.
// Reset (rst, synchronous) empties the pipes and the queue and loads the
// register defaults: all zero except max_depth = 0xFFFFFF.
module depth_box_backprojection_unit #(
  parameter int SAMPLE_STRIDE = 3,
  parameter int QUEUE_DEPTH   = 8
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: column[11:0], pixel_row[23:12], depth_raw[39:24], red[47:40],
  //          green[55:48], blue[63:56]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,
  // m_tdata: point_x[31:0], point_y[63:32], point_z[87:64], out_red[95:88],
  //          out_green[103:96], out_blue[111:104]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dbb_pkg::cfg_t     cfg;
  dbb_pkg::reg_idx_t idx;

  logic              take;
  logic [1:0]        inflight;
  logic              push, pop, empty;
  dbb_pkg::item_t    push_item, head;
  logic [CW-1:0]     count;

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;
  assign idx    = dbb_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{max_depth: 24'hFF_FFFF, default: '0};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        dbb_pkg::REG_BOX_START:       cfg.box_start       <= pwdata[23:0];
        dbb_pkg::REG_BOX_END:         cfg.box_end         <= pwdata[23:0];
        dbb_pkg::REG_CENTER_X:        cfg.center_x        <= pwdata[15:0];
        dbb_pkg::REG_CENTER_Y:        cfg.center_y        <= pwdata[15:0];
        dbb_pkg::REG_INV_FOCAL_X:     cfg.inv_focal_x     <= pwdata[23:0];
        dbb_pkg::REG_INV_FOCAL_Y:     cfg.inv_focal_y     <= pwdata[23:0];
        dbb_pkg::REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= pwdata[23:0];
        dbb_pkg::REG_MAX_DEPTH:       cfg.max_depth       <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbb_pkg::REG_BOX_START:       prdata = 32'(cfg.box_start);
      dbb_pkg::REG_BOX_END:         prdata = 32'(cfg.box_end);
      dbb_pkg::REG_CENTER_X:        prdata = 32'(cfg.center_x);
      dbb_pkg::REG_CENTER_Y:        prdata = 32'(cfg.center_y);
      dbb_pkg::REG_INV_FOCAL_X:     prdata = 32'(cfg.inv_focal_x);
      dbb_pkg::REG_INV_FOCAL_Y:     prdata = 32'(cfg.inv_focal_y);
      dbb_pkg::REG_INV_DEPTH_SCALE: prdata = 32'(cfg.inv_depth_scale);
      dbb_pkg::REG_MAX_DEPTH:       prdata = 32'(cfg.max_depth);
    endcase
  end

  // ---------------- input side ----------------
  // Every pixel in the front holds a queue credit, kept or not.
  assign s_tready = ((CW + 1)'(count) + (CW + 1)'(inflight)) < (CW + 1)'(QUEUE_DEPTH);
  assign take     = s_tvalid && s_tready;

  dbb_front #(
    .SAMPLE_STRIDE(SAMPLE_STRIDE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .pixel    (s_tdata),
    .cfg      (cfg),
    .inflight (inflight),
    .push     (push),
    .item     (push_item)
  );

  dbb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .count (count)
  );

  // ---------------- output side ----------------
  dbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (!empty),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

@@ hdl/dbb_front.sv @@
module dbb_front #(
  parameter int SAMPLE_STRIDE = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [63:0]    pixel,
  input  dbb_pkg::cfg_t  cfg,
  output logic [1:0]     inflight,
  output logic           push,
  output dbb_pkg::item_t item
);

  localparam int SH = 24;
  localparam int STRIDE_W = $clog2(SAMPLE_STRIDE + 1);
  localparam int RW = 12 + STRIDE_W;
  // floor(2^SH / stride): quotient estimate is exact or one low
  localparam logic [SH:0] RECIP = (SH + 1)'((64'd1 << SH) / SAMPLE_STRIDE);

  logic [11:0] col, row, left, top, right, bottom, dcol, drow;
  logic [15:0] raw;
  logic [SH+12:0] qc_full, qr_full;
  logic [39:0] z_full;

  // stage 1
  logic        v1;
  logic        inbox1;
  logic [11:0] dcol1, drow1, qcol1, qrow1, col1, row1;
  logic [31:0] z1;
  logic [7:0]  red1, green1, blue1;

  // stage 2
  logic           v2;
  logic           keep2;
  dbb_pkg::item_t item2;

  logic [RW-1:0]  rc, rr;
  logic           lat_ok, z_ok, keep;
  logic [15:0]    col16, row16;
  dbb_pkg::item_t item_d;

  assign col    = pixel[11:0];
  assign row    = pixel[23:12];
  assign raw    = pixel[39:24];
  assign left   = cfg.box_start[11:0];
  assign top    = cfg.box_start[23:12];
  assign right  = cfg.box_end[11:0];
  assign bottom = cfg.box_end[23:12];
  assign dcol   = col - left;
  assign drow   = row - top;

  assign qc_full = (SH + 13)'(dcol) * (SH + 13)'(RECIP);
  assign qr_full = (SH + 13)'(drow) * (SH + 13)'(RECIP);
  assign z_full  = 40'(raw) * 40'(cfg.inv_depth_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    inbox1 <= (col >= left) && (col < right) && (row >= top) && (row < bottom);
    dcol1  <= dcol;
    drow1  <= drow;
    qcol1  <= qc_full[SH+11:SH];
    qrow1  <= qr_full[SH+11:SH];
    z1     <= z_full[39:8];
    col1   <= col;
    row1   <= row;
    red1   <= pixel[47:40];
    green1 <= pixel[55:48];
    blue1  <= pixel[63:56];
  end

  // remainder in [0, 2*stride) after the estimate
  always_comb begin
    rc = RW'(dcol1) - RW'(qcol1) * RW'(SAMPLE_STRIDE);
    rr = RW'(drow1) - RW'(qrow1) * RW'(SAMPLE_STRIDE);
    lat_ok = ((rc == '0) || (rc == RW'(SAMPLE_STRIDE))) &&
             ((rr == '0) || (rr == RW'(SAMPLE_STRIDE)));
    z_ok = (z1 > dbb_pkg::MIN_Z) && (z1 <= {8'd0, cfg.max_depth});
    keep = inbox1 && lat_ok && z_ok;

    col16 = {col1, 4'd0};
    row16 = {row1, 4'd0};
    item_d.z     = z1[23:0];
    item_d.neg_x = col16 < cfg.center_x;
    item_d.mag_x = item_d.neg_x ? cfg.center_x - col16 : col16 - cfg.center_x;
    item_d.neg_y = row16 < cfg.center_y;
    item_d.mag_y = item_d.neg_y ? cfg.center_y - row16 : row16 - cfg.center_y;
    item_d.red   = red1;
    item_d.green = green1;
    item_d.blue  = blue1;
  end

  always_ff @(posedge clk) begin
    keep2 <= keep;
    item2 <= item_d;
  end

  assign inflight = {1'b0, v1} + {1'b0, v2};
  assign push     = v2 && keep2;
  assign item     = item2;

endmodule

@@ hdl/dbb_queue.sv @@
module dbb_queue #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  dbb_pkg::item_t               wdata,
  input  logic                         pop,
  output dbb_pkg::item_t               rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dbb_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wptr, rptr;

  // push is never issued when full: the front holds credits for it
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  assign rdata = mem[rptr];
  assign empty = (count == '0);

endmodule

@@ hdl/dbb_back.sv @@
module dbb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  dbb_pkg::item_t head,
  output logic           pop,
  input  dbb_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [111:0]   out_data
);

  // (hi*4096 + lo) >> 28, sign applied, saturated to 32 bits
  function automatic logic [31:0] finish(input logic [51:0] hi, input logic [51:0] lo,
                                         input logic neg);
    logic [52:0] sum;
    logic [36:0] q;
    logic [31:0] sat;
    sum = 53'(hi) + 53'(lo[51:12]);
    q   = sum[52:16];
    if (!neg) begin
      finish = (q > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat    = (q > 37'h0_8000_0000) ? 32'h8000_0000 : q[31:0];
      finish = 32'd0 - sat;
    end
  endfunction

  logic en;

  logic        v1;
  logic [39:0] px1, py1;
  logic        nx1, ny1;
  logic [23:0] z1;
  logic [23:0] rgb1;

  logic        v2;
  logic [51:0] hx2, lx2, hy2, ly2;
  logic        nx2, ny2;
  logic [23:0] z2;
  logic [23:0] rgb2;

  // whole pipe moves when the output slot is free or being taken
  assign en  = !out_valid || out_ready;
  assign pop = en && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= avail;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= 40'(head.mag_x) * 40'(head.z);
      py1  <= 40'(head.mag_y) * 40'(head.z);
      nx1  <= head.neg_x;
      ny1  <= head.neg_y;
      z1   <= head.z;
      rgb1 <= {head.blue, head.green, head.red};

      hx2  <= 52'(px1) * 52'(cfg.inv_focal_x[23:12]);
      lx2  <= 52'(px1) * 52'(cfg.inv_focal_x[11:0]);
      hy2  <= 52'(py1) * 52'(cfg.inv_focal_y[23:12]);
      ly2  <= 52'(py1) * 52'(cfg.inv_focal_y[11:0]);
      nx2  <= nx1;
      ny2  <= ny1;
      z2   <= z1;
      rgb2 <= rgb1;

      out_data <= {rgb2, z2, finish(hy2, ly2, ny2), finish(hx2, lx2, nx2)};
    end
  end

endmodule

@@ hdl/dbb_checker.sv @@
module dbb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);

  // a stalled point stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // reset empties the back pipe
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid after reset");

  // queue is empty after reset, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low after reset");

  // near cut: every emitted point_z lies beyond 0.1 m
  a_near_cut: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[87:64] > 24'd6553)
    else $error("point_z at or below near cut");

endmodule

bind depth_box_backprojection_unit dbb_checker u_dbb_checker (.*);
